// ===== rtl/cpu8_alu_flags_unit_assert.svh =====
// Assertion macros used by the checker module of the ALU block.
`ifndef CPU8_ALU_FLAGS_UNIT_ASSERT_SVH
`define CPU8_ALU_FLAGS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, quiet during reset.
`define CPU8ALU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, quiet during reset.
`define CPU8ALU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cpu8alu_pkg.sv =====
// Opcodes, write targets, rotate kinds and shared types of the 8-bit ALU.
package cpu8alu_pkg;

  localparam int OpW = 5;

  localparam logic [OpW-1:0] OP_ADD  = 5'd0;
  localparam logic [OpW-1:0] OP_ADC  = 5'd1;
  localparam logic [OpW-1:0] OP_SUB  = 5'd2;
  localparam logic [OpW-1:0] OP_SBC  = 5'd3;
  localparam logic [OpW-1:0] OP_AND  = 5'd4;
  localparam logic [OpW-1:0] OP_OR   = 5'd5;
  localparam logic [OpW-1:0] OP_XOR  = 5'd6;
  localparam logic [OpW-1:0] OP_CP   = 5'd7;
  localparam logic [OpW-1:0] OP_INC  = 5'd8;
  localparam logic [OpW-1:0] OP_DEC  = 5'd9;
  localparam logic [OpW-1:0] OP_SWAP = 5'd10;
  localparam logic [OpW-1:0] OP_CPL  = 5'd11;
  localparam logic [OpW-1:0] OP_CCF  = 5'd12;
  localparam logic [OpW-1:0] OP_SCF  = 5'd13;
  localparam logic [OpW-1:0] OP_RLCA = 5'd14;
  localparam logic [OpW-1:0] OP_RLA  = 5'd15;
  localparam logic [OpW-1:0] OP_RRCA = 5'd16;
  localparam logic [OpW-1:0] OP_RRA  = 5'd17;
  localparam logic [OpW-1:0] OP_RLC  = 5'd18;
  localparam logic [OpW-1:0] OP_RL   = 5'd19;
  localparam logic [OpW-1:0] OP_RRC  = 5'd20;
  localparam logic [OpW-1:0] OP_RR   = 5'd21;
  localparam logic [OpW-1:0] OP_SLA  = 5'd22;
  localparam logic [OpW-1:0] OP_SRA  = 5'd23;
  localparam logic [OpW-1:0] OP_SRL  = 5'd24;
  localparam logic [OpW-1:0] OP_BIT  = 5'd25;
  localparam logic [OpW-1:0] OP_SET  = 5'd26;
  localparam logic [OpW-1:0] OP_RES  = 5'd27;
  localparam logic [OpW-1:0] OP_LDA  = 5'd28;

  localparam logic [1:0] WT_NONE = 2'd0;
  localparam logic [1:0] WT_ACC  = 2'd1;
  localparam logic [1:0] WT_OPND = 2'd2;

  localparam logic [2:0] ROT_RLC = 3'd0;
  localparam logic [2:0] ROT_RL  = 3'd1;
  localparam logic [2:0] ROT_RRC = 3'd2;
  localparam logic [2:0] ROT_RR  = 3'd3;
  localparam logic [2:0] ROT_SLA = 3'd4;
  localparam logic [2:0] ROT_SRA = 3'd5;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [7:0] result;
    logic [1:0] target;
    flags_t     flags;
    logic       unknown;
  } exec_out_t;

endpackage

// ===== rtl/cpu8_alu_flags_unit.sv =====
// Top level of the 8-bit ALU: input register, datapath, result register, state.
// An accepted word waits in the input register, then moves into the result register.
// Throughput: one word per cycle unless the result is stalled; the flags, and the
// accumulator on accumulator writes, update as each word moves into the result register,
// so the next word sees them at once.
// Reset (rst, synchronous): clears both stages, the accumulator and all flags.
module cpu8_alu_flags_unit
  import cpu8alu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] opcode,
  input  logic [7:0] operand,
  input  logic [2:0] bit_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] result,
  output logic [1:0] write_target,
  output logic       zero_flag,
  output logic       subtract_flag,
  output logic       half_carry_flag,
  output logic       carry_flag,
  output logic       unknown_op
);

  logic       in_full;
  logic [4:0] op_q;
  logic [7:0] opnd_q;
  logic [2:0] bidx_q;
  logic [7:0] acc;
  flags_t     flags;
  exec_out_t  exec_res;
  exec_out_t  out_q;
  logic       advance;
  logic       in_take;

  assign advance  = in_full & (~out_valid | ~out_stall);
  assign in_stall = in_full & ~advance;
  assign in_take  = in_valid & ~in_stall;

  cpu8alu_exec u_exec (
    .opcode    (op_q),
    .operand   (opnd_q),
    .bit_index (bidx_q),
    .acc       (acc),
    .flags     (flags),
    .res       (exec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      acc       <= 8'd0;
      flags     <= '0;
    end else begin
      if (in_take) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        flags     <= exec_res.flags;
        if (exec_res.target == WT_ACC) begin
          acc <= exec_res.result;
        end
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers: load on take/advance, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_q   <= opcode;
      opnd_q <= operand;
      bidx_q <= bit_index;
    end
    if (advance) begin
      out_q <= exec_res;
    end
  end

  assign result          = out_q.result;
  assign write_target    = out_q.target;
  assign zero_flag       = out_q.flags.z;
  assign subtract_flag   = out_q.flags.n;
  assign half_carry_flag = out_q.flags.h;
  assign carry_flag      = out_q.flags.c;
  assign unknown_op      = out_q.unknown;

endmodule

// ===== rtl/cpu8alu_exec.sv =====
// Single-pass ALU datapath: result byte, write target and new flags.
module cpu8alu_exec
  import cpu8alu_pkg::*;
(
  input  logic [4:0] opcode,
  input  logic [7:0] operand,
  input  logic [2:0] bit_index,
  input  logic [7:0] acc,
  input  flags_t     flags,
  output exec_out_t  res
);

  logic [8:0] sum9;
  logic [4:0] sum5;
  logic [8:0] dif9;
  logic [4:0] dif5;
  logic       cin_t;
  logic [7:0] rot_src;
  logic [4:0] rot_off;
  logic [2:0] rot_kind;
  logic [7:0] rot_r;
  logic       rot_c;
  logic [7:0] bit_mask;
  logic [7:0] inc_r;
  logic [7:0] dec_r;

  // carry-in only for the with-carry forms
  assign cin_t = flags.c & ((opcode == OP_ADC) | (opcode == OP_SBC));

  assign sum9 = {1'b0, acc} + {1'b0, operand} + {8'd0, cin_t};
  assign sum5 = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, cin_t};
  assign dif9 = {1'b0, acc} - {1'b0, operand} - {8'd0, cin_t};
  assign dif5 = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'd0, cin_t};

  assign inc_r = operand + 8'd1;
  assign dec_r = operand - 8'd1;
  assign bit_mask = 8'd1 << bit_index;

  // accumulator rotates and operand rotates/shifts share one shifter
  assign rot_src  = (opcode <= OP_RRA) ? acc : operand;
  assign rot_off  = (opcode <= OP_RRA) ? (opcode - OP_RLCA) : (opcode - OP_RLC);
  assign rot_kind = rot_off[2:0];

  always_comb begin
    unique case (rot_kind)
      ROT_RLC: begin
        rot_r = {rot_src[6:0], rot_src[7]};
        rot_c = rot_src[7];
      end
      ROT_RL: begin
        rot_r = {rot_src[6:0], flags.c};
        rot_c = rot_src[7];
      end
      ROT_RRC: begin
        rot_r = {rot_src[0], rot_src[7:1]};
        rot_c = rot_src[0];
      end
      ROT_RR: begin
        rot_r = {flags.c, rot_src[7:1]};
        rot_c = rot_src[0];
      end
      ROT_SLA: begin
        rot_r = {rot_src[6:0], 1'b0};
        rot_c = rot_src[7];
      end
      ROT_SRA: begin
        rot_r = {rot_src[7], rot_src[7:1]};
        rot_c = rot_src[0];
      end
      default: begin
        rot_r = {1'b0, rot_src[7:1]};
        rot_c = rot_src[0];
      end
    endcase
  end

  always_comb begin
    res.result  = acc;
    res.target  = WT_NONE;
    res.flags   = flags;
    res.unknown = 1'b0;
    unique case (opcode)
      OP_ADD, OP_ADC: begin
        res.result = sum9[7:0];
        res.target = WT_ACC;
        res.flags  = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: sum5[4], c: sum9[8]};
      end
      OP_SUB, OP_SBC: begin
        res.result = dif9[7:0];
        res.target = WT_ACC;
        res.flags  = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: dif5[4], c: dif9[8]};
      end
      OP_CP: begin
        res.flags = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: dif5[4], c: dif9[8]};
      end
      OP_AND: begin
        res.result = acc & operand;
        res.target = WT_ACC;
        res.flags  = '{z: ((acc & operand) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      OP_OR: begin
        res.result = acc | operand;
        res.target = WT_ACC;
        res.flags  = '{z: ((acc | operand) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_XOR: begin
        res.result = acc ^ operand;
        res.target = WT_ACC;
        res.flags  = '{z: ((acc ^ operand) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_INC: begin
        res.result = inc_r;
        res.target = WT_OPND;
        res.flags  = '{z: (inc_r == 8'd0), n: 1'b0, h: (operand[3:0] == 4'hF),
                       c: flags.c};
      end
      OP_DEC: begin
        res.result = dec_r;
        res.target = WT_OPND;
        res.flags  = '{z: (dec_r == 8'd0), n: 1'b1, h: (operand[3:0] == 4'h0),
                       c: flags.c};
      end
      OP_SWAP: begin
        res.result = {operand[3:0], operand[7:4]};
        res.target = WT_OPND;
        res.flags  = '{z: (operand == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_CPL: begin
        res.result = ~acc;
        res.target = WT_ACC;
        res.flags  = '{z: flags.z, n: 1'b1, h: 1'b1, c: flags.c};
      end
      OP_CCF: begin
        res.flags = '{z: flags.z, n: 1'b0, h: 1'b0, c: ~flags.c};
      end
      OP_SCF: begin
        res.flags = '{z: flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      OP_RLCA, OP_RLA, OP_RRCA, OP_RRA: begin
        res.result = rot_r;
        res.target = WT_ACC;
        res.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: rot_c};
      end
      OP_RLC, OP_RL, OP_RRC, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
        res.result = rot_r;
        res.target = WT_OPND;
        res.flags  = '{z: (rot_r == 8'd0), n: 1'b0, h: 1'b0, c: rot_c};
      end
      OP_BIT: begin
        res.flags = '{z: ((operand & bit_mask) == 8'd0), n: 1'b0, h: 1'b1, c: flags.c};
      end
      OP_SET: begin
        res.result = operand | bit_mask;
        res.target = WT_OPND;
      end
      OP_RES: begin
        res.result = operand & ~bit_mask;
        res.target = WT_OPND;
      end
      OP_LDA: begin
        res.result = operand;
        res.target = WT_ACC;
      end
      default: begin
        res.unknown = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/cpu8alu_checker.sv =====
// Port-level checks for the ALU block, bound to the top level.
`include "cpu8_alu_flags_unit_assert.svh"

module cpu8alu_checker
  import cpu8alu_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [4:0] opcode,
  input logic [7:0] operand,
  input logic [2:0] bit_index,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] result,
  input logic [1:0] write_target,
  input logic       zero_flag,
  input logic       subtract_flag,
  input logic       half_carry_flag,
  input logic       carry_flag,
  input logic       unknown_op
);

  // a stalled result word holds
  `CPU8ALU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(result) && $stable(write_target) && $stable(unknown_op),
    "stalled result word changed")

  // an undefined opcode writes nothing
  `CPU8ALU_ASSERT_IMPLY(a_unknown_no_write, clk, rst, out_valid && unknown_op,
    write_target == WT_NONE, "undefined opcode reported a write")

  // only three write target codes exist
  `CPU8ALU_ASSERT_IMPLY(a_target_code, clk, rst, out_valid,
    write_target == WT_NONE || write_target == WT_ACC || write_target == WT_OPND,
    "write target code out of range")

  // an undefined opcode leaves flags as the previous word left them
  `CPU8ALU_ASSERT_NEXT(a_unknown_keeps_flags, clk, rst,
    out_valid && !out_stall,
    !(out_valid && unknown_op && $past(out_valid) && !$past(out_stall)) ||
    (zero_flag == $past(zero_flag) && subtract_flag == $past(subtract_flag) &&
     half_carry_flag == $past(half_carry_flag) && carry_flag == $past(carry_flag)),
    "undefined opcode changed the flags")

endmodule

bind cpu8_alu_flags_unit cpu8alu_checker u_checker (.*);
